/* rtl/sed_pkg.sv */
// ---------------------------------------------------------------------------
// sed_pkg: shared types and constants for the string escape decoder
// Result record, error codes and character codes used by the decoder and
// its result queue.
// ---------------------------------------------------------------------------
`default_nettype none

package sed_pkg;

    // Error codes carried by a result
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_CLOSE = 3'd1;
    localparam logic [2:0] ERR_EMB_NUL  = 3'd2;
    localparam logic [2:0] ERR_OCT_BIG  = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd4;
    localparam logic [2:0] ERR_UNK_ESC  = 3'd5;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_X     = 8'h78;

    // Result queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One result item
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic       literal_done;
        logic       held_back;
        logic       last_of_run;
    } t_result;

endpackage : sed_pkg

`default_nettype wire

/* rtl/sed_decode.sv */
// ---------------------------------------------------------------------------
// sed_decode: escape decoding logic and decode state
// Turns one registered source byte into zero, one or two results and
// advances the decode mode and code accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module sed_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_at_buffer_end,
    output sed_pkg::t_result      o_res0,
    output sed_pkg::t_result      o_res1,
    output logic [1:0]            o_count
);
    import sed_pkg::*;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESC,
        M_CRSPLICE,
        M_OCT1,
        M_OCT2,
        M_HEX0,
        M_HEX1,
        M_DONE
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [8:0] r_acc, n_acc;

    // Normal in-string handling of the current byte
    logic    nb_emit;
    t_result nb_res;
    t_mode   nb_mode;

    // Digit classification
    logic       is_oct;
    logic [2:0] oct_dig;
    logic [8:0] oct_acc;
    logic       is_hex;
    logic [3:0] hex_dig;
    t_result    pend_res;
    t_result    res0, res1;
    logic [1:0] cnt;

    // Classify the byte as octal or hex digit
    always_comb begin
        is_oct  = (i_ch >= CH_ZERO) && (i_ch <= CH_SEVEN);
        oct_dig = i_ch[2:0];
        oct_acc = {r_acc[5:0], oct_dig};
        is_hex  = 1'b0;
        hex_dig = 4'd0;
        if ((i_ch >= CH_ZERO) && (i_ch <= CH_NINE)) begin
            is_hex  = 1'b1;
            hex_dig = i_ch[3:0];
        end else if (((i_ch >= CH_LA) && (i_ch <= CH_LF_A))
                  || ((i_ch >= CH_UA) && (i_ch <= CH_UF))) begin
            is_hex  = 1'b1;
            hex_dig = i_ch[3:0] + 4'd9;
        end
    end

    // Handle the byte as plain string content
    always_comb begin
        nb_emit = 1'b1;
        nb_res  = '0;
        nb_mode = M_NORMAL;
        if (i_at_buffer_end || (i_ch == CH_LF) || (i_ch == CH_CR)) begin
            nb_res.error_code   = ERR_NO_CLOSE;
            nb_res.literal_done = 1'b1;
            nb_res.held_back    = 1'b1;
            nb_mode             = M_DONE;
        end else if (i_ch == CH_BSL) begin
            nb_emit = 1'b0;
            nb_mode = M_ESC;
        end else if (i_ch == CH_QUOTE) begin
            nb_res.literal_done = 1'b1;
            nb_mode             = M_DONE;
        end else if (i_ch == CH_NUL) begin
            nb_res.error_code = ERR_EMB_NUL;
        end else begin
            nb_res.has_byte  = 1'b1;
            nb_res.data_byte = i_ch;
        end
    end

    // Pending escape value emitted ahead of a non-digit byte
    always_comb begin
        pend_res           = '0;
        pend_res.has_byte  = 1'b1;
        pend_res.data_byte = r_acc[7:0];
    end

    // Mode dispatch
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        res0   = '0;
        res1   = '0;
        cnt    = 2'd0;
        case (r_mode)
            M_NORMAL: begin
                n_mode = nb_mode;
                n_acc  = '0;
                res0   = nb_res;
                cnt    = {1'b0, nb_emit};
            end
            M_ESC: begin
                n_mode = M_NORMAL;
                n_acc  = '0;
                cnt    = 2'd1;
                if (i_at_buffer_end) begin
                    res0.error_code   = ERR_NO_CLOSE;
                    res0.literal_done = 1'b1;
                    res0.held_back    = 1'b1;
                    n_mode            = M_DONE;
                end else begin
                    res0.has_byte = 1'b1;
                    case (i_ch)
                        CH_N:     res0.data_byte = CH_LF;
                        CH_T:     res0.data_byte = CH_TAB;
                        CH_BSL:   res0.data_byte = CH_BSL;
                        CH_QUOTE: res0.data_byte = CH_QUOTE;
                        CH_V:     res0.data_byte = CH_VT;
                        CH_LF_A:  res0.data_byte = CH_FF;
                        CH_LA:    res0.data_byte = CH_BEL;
                        CH_LF: begin
                            cnt = 2'd0;
                        end
                        CH_CR: begin
                            cnt    = 2'd0;
                            n_mode = M_CRSPLICE;
                        end
                        CH_X: begin
                            cnt    = 2'd0;
                            n_mode = M_HEX0;
                        end
                        default: begin
                            if (is_oct) begin
                                cnt    = 2'd0;
                                n_acc  = {6'd0, oct_dig};
                                n_mode = M_OCT1;
                            end else begin
                                res0.data_byte  = i_ch;
                                res0.error_code = ERR_UNK_ESC;
                            end
                        end
                    endcase
                end
            end
            M_CRSPLICE: begin
                n_acc = '0;
                if (!i_at_buffer_end && (i_ch == CH_LF)) begin
                    n_mode = M_NORMAL;
                end else begin
                    n_mode = nb_mode;
                    res0   = nb_res;
                    cnt    = {1'b0, nb_emit};
                end
            end
            M_OCT1, M_OCT2: begin
                if (!i_at_buffer_end && is_oct) begin
                    if (r_mode == M_OCT1) begin
                        n_acc  = oct_acc;
                        n_mode = M_OCT2;
                    end else begin
                        n_acc  = '0;
                        n_mode = M_NORMAL;
                        cnt    = 2'd1;
                        if (oct_acc[8]) begin
                            res0.error_code = ERR_OCT_BIG;
                        end else begin
                            res0.has_byte  = 1'b1;
                            res0.data_byte = oct_acc[7:0];
                        end
                    end
                end else begin
                    n_acc  = '0;
                    n_mode = nb_mode;
                    res0   = pend_res;
                    res1   = nb_res;
                    cnt    = nb_emit ? 2'd2 : 2'd1;
                end
            end
            M_HEX0: begin
                cnt = 2'd1;
                if (i_at_buffer_end) begin
                    res0.error_code   = ERR_NO_CLOSE;
                    res0.literal_done = 1'b1;
                    res0.held_back    = 1'b1;
                    n_acc             = '0;
                    n_mode            = M_DONE;
                end else if (!is_hex) begin
                    res0.has_byte   = 1'b1;
                    res0.data_byte  = i_ch;
                    res0.error_code = ERR_BAD_HEX;
                    n_acc           = '0;
                    n_mode          = M_NORMAL;
                end else begin
                    cnt    = 2'd0;
                    n_acc  = {5'd0, hex_dig};
                    n_mode = M_HEX1;
                end
            end
            M_HEX1: begin
                n_acc = '0;
                if (!i_at_buffer_end && is_hex) begin
                    n_mode         = M_NORMAL;
                    res0.has_byte  = 1'b1;
                    res0.data_byte = {r_acc[3:0], hex_dig};
                    cnt            = 2'd1;
                end else begin
                    n_mode = nb_mode;
                    res0   = pend_res;
                    res1   = nb_res;
                    cnt    = nb_emit ? 2'd2 : 2'd1;
                end
            end
            default: begin
                // literal ended: drop everything until reset
                cnt = 2'd0;
            end
        endcase
        // mark the final result of this byte
        res0.last_of_run = (cnt == 2'd1);
        res1.last_of_run = 1'b1;
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = cnt;

    // Hold decode state, advance on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_acc  <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule : sed_decode

`default_nettype wire

/* rtl/sed_result_queue.sv */
// ---------------------------------------------------------------------------
// sed_result_queue: small result queue
// Takes up to two results per cycle and hands out one per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module sed_result_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push_count,
    input  wire sed_pkg::t_result i_res0,
    input  wire sed_pkg::t_result i_res1,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sed_pkg::t_result      o_res
);
    import sed_pkg::*;

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                pop;
    logic [QPTR_W-1:0]   wr_next;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + QPTR_W'(1);

    // Room for two more results once this cycle's pop is counted
    assign o_room = (r_cnt <= QCNT_W'(QDEPTH - 2))
                 || ((r_cnt == QCNT_W'(QDEPTH - 1)) && pop);

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push_count);
        n_rd  = pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

endmodule : sed_result_queue

`default_nettype wire

/* rtl/string_escape_decoder_unit.sv */
// ---------------------------------------------------------------------------
// string_escape_decoder_unit: string literal escape decoder
// Takes the bytes of a string literal after its opening quote, one per
// transaction, and delivers the decoded characters and diagnostics.
//
// Each source byte is registered on input and decoded from that register
// once the queue has room; its zero, one or two results go into a
// four-entry result queue. A new byte is taken every cycle while the queue
// has room for two results; the output side delivers one result per cycle
// while the receiver is ready, so a byte that ends an octal or hex escape
// and also yields its own result takes two output transactions. A result
// passes the input register and then the queue before it is offered. After
// the literal has ended, further bytes are taken and dropped until reset.
// ---------------------------------------------------------------------------
`default_nettype none

module string_escape_decoder_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_at_buffer_end,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_has_byte,
    output logic [7:0]      o_data_byte,
    output logic [2:0]      o_error_code,
    output logic            o_literal_done,
    output logic            o_held_back,
    output logic            o_last_of_run
);
    import sed_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_ch;
    logic       r_in_end;
    logic       room;
    logic       advance;
    t_result    res0, res1, out_res;
    logic [1:0] dec_count;
    logic [1:0] push_count;

    assign advance    = r_in_vld && room;
    assign o_ready    = !r_in_vld || advance;
    assign push_count = advance ? dec_count : 2'd0;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_ch  <= i_ch;
            r_in_end <= i_at_buffer_end;
        end
    end

    sed_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_ch            (r_in_ch),
        .i_at_buffer_end (r_in_end),
        .o_res0          (res0),
        .o_res1          (res1),
        .o_count         (dec_count)
    );

    sed_result_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (res0),
        .i_res1       (res1),
        .o_room       (room),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (out_res)
    );

    // Unpack the result at the head of the queue
    assign o_has_byte     = out_res.has_byte;
    assign o_data_byte    = out_res.data_byte;
    assign o_error_code   = out_res.error_code;
    assign o_literal_done = out_res.literal_done;
    assign o_held_back    = out_res.held_back;
    assign o_last_of_run  = out_res.last_of_run;

endmodule : string_escape_decoder_unit

`default_nettype wire

/* verif/string_escape_decoder_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// string_escape_decoder_unit_test: self-checking bench for the escape decoder
// Feeds one long string literal built from plain text, simple escapes, line
// splices, octal and hex escapes and malformed escapes, then closes it with a
// randomly chosen ending and a few bytes that must be dropped. A scoreboard
// decodes every accepted byte itself and checks each delivered result, field
// by field, in order. Both handshakes idle at random in the first two of three
// phases; the receiver holds off once for a long stretch so the queue fills.
// ---------------------------------------------------------------------------

module string_escape_decoder_unit_test;

    import sed_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int PHASE_LEN       = 580;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_PRINTED     = 100;
    localparam int OCT_BASE        = 8;
    localparam int HEX_BASE        = 16;
    localparam int OCT_LIMIT       = 255;

    // Decoder state as tracked by the scoreboard
    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESCAPE,
        MODE_CR_SPLICE,
        MODE_OCT1,
        MODE_OCT2,
        MODE_HEX0,
        MODE_HEX1,
        MODE_ENDED
    } t_decode_mode;

    // Ways of closing the literal at the end of the run
    typedef enum int {
        END_QUOTE,
        END_BARE_LF,
        END_BARE_CR,
        END_BUF,
        END_BUF_AFTER_BSL,
        END_BUF_AFTER_X,
        END_BUF_AFTER_OCT,
        END_BUF_AFTER_HEX,
        END_BUF_AFTER_CR,
        END_QUOTE_AFTER_OCT
    } t_ending;

    localparam logic [7:0] SIMPLE_ESC [7] =
        '{CH_N, CH_T, CH_BSL, CH_QUOTE, CH_V, CH_LF_A, CH_LA};

    // -----------------------------------------------------------------------
    // Scoreboard: decodes source bytes and checks the delivered results
    // -----------------------------------------------------------------------
    class decoded_char_checker;
        t_result      decoded_q[$];
        t_result      run_q[$];
        t_decode_mode mode;
        logic [8:0]   accum;
        int           mismatch_count;
        int           results_seen;

        function new();
            mode           = MODE_TEXT;
            accum          = '0;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction

        function bit is_octal(logic [7:0] ch);
            return ch >= CH_ZERO && ch <= CH_SEVEN;
        endfunction

        function int hex_value(logic [7:0] ch);
            if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
            if (ch >= CH_LA && ch <= CH_LF_A) return int'(ch - CH_LA) + 10;
            if (ch >= CH_UA && ch <= CH_UF) return int'(ch - CH_UA) + 10;
            return -1;
        endfunction

        function void emit(logic has, logic [7:0] data, logic [2:0] err, logic done,
                           logic held);
            t_result r;
            r.has_byte     = has;
            r.data_byte    = has ? data : 8'h00;
            r.error_code   = err;
            r.literal_done = done;
            r.held_back    = held;
            r.last_of_run  = 1'b0;
            run_q.push_back(r);
        endfunction

        function void end_unterminated();
            mode  = MODE_ENDED;
            accum = '0;
            emit(1'b0, 8'h00, ERR_NO_CLOSE, 1'b1, 1'b1);
        endfunction

        // Ordinary in-string handling of one byte
        function void plain_byte(logic [7:0] ch, logic at_end);
            mode  = MODE_TEXT;
            accum = '0;
            if (at_end || ch == CH_LF || ch == CH_CR) begin
                end_unterminated();
            end else if (ch == CH_BSL) begin
                mode = MODE_ESCAPE;
            end else if (ch == CH_QUOTE) begin
                mode = MODE_ENDED;
                emit(1'b0, 8'h00, ERR_NONE, 1'b1, 1'b0);
            end else if (ch == CH_NUL) begin
                emit(1'b0, 8'h00, ERR_EMB_NUL, 1'b0, 1'b0);
            end else begin
                emit(1'b1, ch, ERR_NONE, 1'b0, 1'b0);
            end
        endfunction

        // Advance the decoder by one accepted byte and queue its results
        function void note_source_byte(logic [7:0] ch, logic at_end);
            logic [8:0] acc;
            int         h;
            t_result    r;
            acc = accum;
            run_q.delete();
            case (mode)
                MODE_TEXT: begin
                    plain_byte(ch, at_end);
                end
                MODE_ESCAPE: begin
                    if (at_end) begin
                        end_unterminated();
                    end else begin
                        mode  = MODE_TEXT;
                        accum = '0;
                        case (ch)
                            CH_N:     emit(1'b1, CH_LF, ERR_NONE, 1'b0, 1'b0);
                            CH_T:     emit(1'b1, CH_TAB, ERR_NONE, 1'b0, 1'b0);
                            CH_BSL:   emit(1'b1, CH_BSL, ERR_NONE, 1'b0, 1'b0);
                            CH_QUOTE: emit(1'b1, CH_QUOTE, ERR_NONE, 1'b0, 1'b0);
                            CH_V:     emit(1'b1, CH_VT, ERR_NONE, 1'b0, 1'b0);
                            CH_LF_A:  emit(1'b1, CH_FF, ERR_NONE, 1'b0, 1'b0);
                            CH_LA:    emit(1'b1, CH_BEL, ERR_NONE, 1'b0, 1'b0);
                            // line splice: nothing to deliver
                            CH_LF:    ;
                            CH_CR:    mode = MODE_CR_SPLICE;
                            CH_X:     mode = MODE_HEX0;
                            default: begin
                                if (is_octal(ch)) begin
                                    accum = 9'(ch - CH_ZERO);
                                    mode  = MODE_OCT1;
                                end else begin
                                    emit(1'b1, ch, ERR_UNK_ESC, 1'b0, 1'b0);
                                end
                            end
                        endcase
                    end
                end
                MODE_CR_SPLICE: begin
                    if (!at_end && ch == CH_LF) begin
                        mode  = MODE_TEXT;
                        accum = '0;
                    end else begin
                        plain_byte(ch, at_end);
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (!at_end && is_octal(ch)) begin
                        acc = 9'(int'(acc) * OCT_BASE + int'(ch - CH_ZERO));
                        if (mode == MODE_OCT1) begin
                            accum = acc;
                            mode  = MODE_OCT2;
                        end else begin
                            mode  = MODE_TEXT;
                            accum = '0;
                            if (int'(acc) > OCT_LIMIT)
                                emit(1'b0, 8'h00, ERR_OCT_BIG, 1'b0, 1'b0);
                            else
                                emit(1'b1, acc[7:0], ERR_NONE, 1'b0, 1'b0);
                        end
                    end else begin
                        // flush the pending value, then treat the byte as text
                        emit(1'b1, acc[7:0], ERR_NONE, 1'b0, 1'b0);
                        plain_byte(ch, at_end);
                    end
                end
                MODE_HEX0: begin
                    if (at_end) begin
                        end_unterminated();
                    end else begin
                        h = hex_value(ch);
                        if (h < 0) begin
                            mode  = MODE_TEXT;
                            accum = '0;
                            emit(1'b1, ch, ERR_BAD_HEX, 1'b0, 1'b0);
                        end else begin
                            accum = 9'(h);
                            mode  = MODE_HEX1;
                        end
                    end
                end
                MODE_HEX1: begin
                    h = at_end ? -1 : hex_value(ch);
                    if (h >= 0) begin
                        mode  = MODE_TEXT;
                        accum = '0;
                        emit(1'b1, 8'(int'(acc) * HEX_BASE + h), ERR_NONE, 1'b0, 1'b0);
                    end else begin
                        emit(1'b1, acc[7:0], ERR_NONE, 1'b0, 1'b0);
                        plain_byte(ch, at_end);
                    end
                end
                default: begin
                    // literal has ended: drop the byte
                end
            endcase
            foreach (run_q[i]) begin
                r             = run_q[i];
                r.last_of_run = (i == run_q.size() - 1);
                decoded_q.push_back(r);
            end
        endfunction

        task report(string msg);
            mismatch_count++;
            // keep the log short if the design is badly broken
            if (mismatch_count <= MAX_PRINTED)
                $display("ERROR: %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %h, expected %h",
                                 results_seen, name, got, want));
        endtask

        // Compare one delivered result with the oldest decoded one
        task check_result(t_result got);
            t_result want;
            if (decoded_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding",
                                 results_seen));
            end else begin
                want = decoded_q.pop_front();
                check_field("has_byte", 8'(got.has_byte), 8'(want.has_byte));
                check_field("data_byte", got.data_byte, want.data_byte);
                check_field("error_code", 8'(got.error_code), 8'(want.error_code));
                check_field("literal_done", 8'(got.literal_done), 8'(want.literal_done));
                check_field("held_back", 8'(got.held_back), 8'(want.held_back));
                check_field("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
            end
            results_seen++;
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Signals and design instance
    // -----------------------------------------------------------------------
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_ch            = 8'h00;
    logic       i_at_buffer_end = 1'b0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_has_byte;
    logic [7:0] o_data_byte;
    logic [2:0] o_error_code;
    logic       o_literal_done;
    logic       o_held_back;
    logic       o_last_of_run;
    t_result    seen_result;

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    bit hold_off_req      = 1'b0;
    int source_bytes_sent = 0;
    int stall_cycles      = 0;

    decoded_char_checker sb;

    assign seen_result = {o_has_byte, o_data_byte, o_error_code, o_literal_done,
                          o_held_back, o_last_of_run};

    string_escape_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_ch            (i_ch),
        .i_at_buffer_end (i_at_buffer_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_byte      (o_has_byte),
        .o_data_byte     (o_data_byte),
        .o_error_code    (o_error_code),
        .o_literal_done  (o_literal_done),
        .o_held_back     (o_held_back),
        .o_last_of_run   (o_last_of_run)
    );

    // Clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Observe both channels, check results and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(seen_result);
            if (i_valid && o_ready)
                sb.note_source_byte(i_ch, i_at_buffer_end);
            if ((o_valid && i_ready) || (i_valid && o_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                sb.report($sformatf("no transaction for %0d cycles, %0d results outstanding",
                                    STALL_LIMIT, sb.outstanding()));
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    // Offer one source byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] ch, input logic at_end);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_ch            <= ch;
        i_at_buffer_end <= at_end;
        do @(posedge i_clk); while (!o_ready);
        source_bytes_sent++;
    endtask

    // One random piece of literal text; never closes the literal
    task automatic send_token();
        int         pick;
        int         n;
        int         v;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // plain character
            do c = 8'($urandom_range(255));
            while (c inside {CH_QUOTE, CH_LF, CH_CR, CH_BSL, CH_NUL});
            send_byte(c, 1'b0);
        end else if (pick < 45) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(SIMPLE_ESC[$urandom_range(6)], 1'b0);
        end else if (pick < 51) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_LF, 1'b0);
        end else if (pick < 56) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_CR, 1'b0);
            send_byte(CH_LF, 1'b0);
        end else if (pick < 68) begin
            // octal escape, one to three digits
            send_byte(CH_BSL, 1'b0);
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'(CH_ZERO + $urandom_range(7)), 1'b0);
        end else if (pick < 80) begin
            // hex escape, one or two digits of either case
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_X, 1'b0);
            n = $urandom_range(1, 2);
            repeat (n) begin
                v = $urandom_range(21);
                if (v < 10)
                    c = 8'(CH_ZERO + v);
                else if (v < 16)
                    c = 8'(CH_LA + v - 10);
                else
                    c = 8'(CH_UA + v - 16);
                send_byte(c, 1'b0);
            end
        end else if (pick < 84) begin
            // hex escape with no digit
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_X, 1'b0);
            do c = 8'($urandom_range(255)); while (sb.hex_value(c) >= 0);
            send_byte(c, 1'b0);
        end else if (pick < 90) begin
            // unknown escape, embedded NUL among them
            send_byte(CH_BSL, 1'b0);
            if ($urandom_range(3) == 0) begin
                c = CH_NUL;
            end else begin
                do c = 8'($urandom_range(255));
                while (c inside {CH_N, CH_T, CH_BSL, CH_QUOTE, CH_V, CH_LF_A, CH_LA,
                                 CH_LF, CH_CR, CH_X} || sb.is_octal(c));
            end
            send_byte(c, 1'b0);
        end else if (pick < 94) begin
            // CR splice left without its LF
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_CR, 1'b0);
        end else begin
            // noise byte, NUL allowed
            do c = 8'($urandom_range(255));
            while (c inside {CH_QUOTE, CH_LF, CH_CR, CH_BSL});
            send_byte(c, 1'b0);
        end
    endtask

    // Main sequence
    initial begin
        logic [7:0] opening[$];
        t_ending    ending;
        bit         pressure_done;

        sb            = new();
        pressure_done = 1'b0;
        opening = '{CH_UA, 8'hFF, CH_NUL,
                    CH_BSL, CH_N, CH_BSL, CH_QUOTE, CH_BSL, CH_LA,
                    CH_BSL, CH_CR, CH_LF, CH_BSL, CH_CR, 8'h5A,
                    CH_BSL, 8'h33, CH_SEVEN, CH_SEVEN,
                    CH_BSL, 8'h34, CH_ZERO, CH_ZERO,
                    CH_BSL, CH_X, CH_UF, CH_LF_A,
                    CH_BSL, CH_X, 8'h5A, CH_BSL, 8'h71};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        send_idle_pct = 9;
        recv_idle_pct = 67;

        // Directed opening: extremes, escapes, splices, octal and hex limits
        foreach (opening[i]) send_byte(opening[i], 1'b0);

        // Random text in three phases; the third runs without idling
        while (source_bytes_sent < RANDOM_ITEMS) begin
            if (source_bytes_sent < PHASE_LEN) begin
                send_idle_pct = 9;
                recv_idle_pct = 67;
            end else if (source_bytes_sent < 2 * PHASE_LEN) begin
                send_idle_pct = 67;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!pressure_done && source_bytes_sent >= HOLD_OFF_AT) begin
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
            end
            send_token();
        end

        // Close the literal one of several ways
        ending = t_ending'($urandom_range(END_QUOTE_AFTER_OCT));
        case (ending)
            END_QUOTE: begin
                send_byte(CH_QUOTE, 1'b0);
            end
            END_BARE_LF: begin
                send_byte(CH_LF, 1'b0);
            end
            END_BARE_CR: begin
                send_byte(CH_CR, 1'b0);
            end
            END_BUF: begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BUF_AFTER_BSL: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BUF_AFTER_X: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_X, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BUF_AFTER_OCT: begin
                send_byte(CH_BSL, 1'b0);
                repeat ($urandom_range(1, 2)) send_byte(8'(CH_ZERO + $urandom_range(7)), 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BUF_AFTER_HEX: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_X, 1'b0);
                send_byte(CH_UF, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            END_BUF_AFTER_CR: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_CR, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            default: begin
                send_byte(CH_BSL, 1'b0);
                send_byte(8'(CH_ZERO + $urandom_range(7)), 1'b0);
                send_byte(CH_QUOTE, 1'b0);
            end
        endcase

        // Bytes after the end must be taken and dropped
        repeat (6) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        i_valid <= 1'b0;

        // Drain, then allow for any stray result
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* string_escape_decoder_unit.f */
rtl/sed_pkg.sv
rtl/sed_decode.sv
rtl/sed_result_queue.sv
rtl/string_escape_decoder_unit.sv
verif/string_escape_decoder_unit_test.sv
